### src/bpmc_pkg.sv
package bpmc_pkg;

    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_CONFIG = 2'd2;

    localparam logic [1:0] VIEW_NORMAL = 2'd0;
    localparam logic [1:0] VIEW_MAX    = 2'd1;
    localparam logic [1:0] VIEW_MIN    = 2'd2;

    localparam logic FIELD_ON  = 1'b0;
    localparam logic FIELD_OFF = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_MIN   = 3'd4;

    localparam logic [15:0]       HOLD_TICKS_RST = 16'd80;
    localparam logic [15:0]       WARN_TICKS_RST = 16'd2000;
    localparam logic signed [7:0] TEMP_MIN_RST   = 8'sd0;
    localparam logic signed [7:0] TEMP_MAX_RST   = 8'sd99;
    localparam logic [6:0]        DIFF_MIN_RST   = 7'd1;
    localparam logic signed [7:0] ON_LEVEL_RST   = 8'sd30;
    localparam logic signed [7:0] OFF_LEVEL_RST  = 8'sd25;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic mode_pin;
        logic up_pin;
        logic down_pin;
    } t_btn_in;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        view;
        logic              edit_field;
        logic signed [7:0] on_threshold;
        logic signed [7:0] off_threshold;
        logic              fan_on;
        logic              warning;
        logic              display_update;
        logic              display_clear;
        logic              save_thresholds;
    } t_panel_out;

    typedef struct packed {
        logic stable;
        logic stable_nxt;
    } t_deb_level;

endpackage

### src/button_panel_mode_controller_top.sv
// channel | dir | handshake                  | payload
// in      | in  | i_in_valid / o_in_ready    | i_in_data  (t_btn_in)
// out     | out | o_out_valid / i_out_ready  | o_out_data (t_panel_out)
// cfg     | in  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// one tick per clock while o_in_ready is high: the whole update runs in the cycle
// of the transfer and the result is registered into a two-entry output queue
// a new tick is taken while one result waits; with two waiting, o_in_ready drops
// synchronous active-low reset restores the power-up thresholds and registers
module button_panel_mode_controller_top #(
    parameter int DEBOUNCE_TICKS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bpmc_pkg::t_btn_in                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bpmc_pkg::t_panel_out                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bpmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bpmc_pkg::*;

    typedef struct packed {
        logic              ok;
        logic signed [7:0] on_lvl;
        logic signed [7:0] off_lvl;
    } t_step;

    function automatic t_step step_threshold(
        input logic              field,
        input logic              up,
        input logic signed [7:0] on_lvl,
        input logic signed [7:0] off_lvl,
        input logic signed [7:0] tmin,
        input logic signed [7:0] tmax,
        input logic [6:0]        dmin
    );
        logic signed [9:0] on_x;
        logic signed [9:0] off_x;
        logic signed [9:0] delta;
        logic signed [9:0] nxt;
        logic signed [9:0] gap;
        logic              bound_ok;
        t_step             res;
        on_x  = $signed({{2{on_lvl[7]}}, on_lvl});
        off_x = $signed({{2{off_lvl[7]}}, off_lvl});
        delta = up ? 10'sd1 : -10'sd1;
        nxt   = (field == FIELD_ON) ? on_x + delta : off_x + delta;
        gap   = (field == FIELD_ON) ? nxt - off_x : on_x - nxt;
        if (up) begin
            bound_ok = nxt <= $signed({{2{tmax[7]}}, tmax});
        end else begin
            bound_ok = nxt >= $signed({{2{tmin[7]}}, tmin});
        end
        res.ok      = bound_ok && (gap >= $signed({3'b000, dmin}));
        res.on_lvl  = on_lvl;
        res.off_lvl = off_lvl;
        if (res.ok) begin
            if (field == FIELD_ON) begin
                res.on_lvl = nxt[7:0];
            end else begin
                res.off_lvl = nxt[7:0];
            end
        end
        return res;
    endfunction

    // config registers
    logic [15:0]       r_hold_ticks;
    logic [15:0]       r_warn_ticks;
    logic signed [7:0] r_temp_min;
    logic signed [7:0] r_temp_max;
    logic [6:0]        r_diff_min;

    // panel state
    logic [15:0]       r_hold_count;
    logic              r_hold_done;
    logic              r_combo_done;
    logic [1:0]        r_mode;
    logic [1:0]        r_earlier_mode;
    logic [1:0]        r_view;
    logic              r_field;
    logic signed [7:0] r_on_level;
    logic signed [7:0] r_off_level;
    logic              r_fan;
    logic              r_warn;
    logic [15:0]       r_warn_count;

    logic [15:0]       n_hold_count;
    logic              n_hold_done;
    logic              n_combo_done;
    logic [1:0]        n_mode;
    logic [1:0]        n_earlier_mode;
    logic [1:0]        n_view;
    logic              n_field;
    logic signed [7:0] n_on_level;
    logic signed [7:0] n_off_level;
    logic              n_fan;
    logic              n_warn;
    logic [15:0]       n_warn_count;
    t_panel_out        n_result;

    // output queue
    t_panel_out r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       in_xfer;
    logic       out_xfer;
    t_deb_level lvl_mode;
    t_deb_level lvl_up;
    t_deb_level lvl_down;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    bpmc_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_deb_mode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_xfer),
        .i_pressed (!i_in_data.mode_pin),
        .o_level   (lvl_mode)
    );

    bpmc_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_deb_up (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_xfer),
        .i_pressed (!i_in_data.up_pin),
        .o_level   (lvl_up)
    );

    bpmc_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_deb_down (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_xfer),
        .i_pressed (!i_in_data.down_pin),
        .o_level   (lvl_down)
    );

    always_comb begin
        logic  upd;
        logic  clr;
        logic  save;
        logic  combo_now;
        t_step st;

        upd       = 1'b0;
        clr       = 1'b0;
        save      = 1'b0;
        combo_now = 1'b0;
        st        = '0;

        n_hold_count   = r_hold_count;
        n_hold_done    = r_hold_done;
        n_combo_done   = r_combo_done;
        n_mode         = r_mode;
        n_earlier_mode = r_earlier_mode;
        n_view         = r_view;
        n_field        = r_field;
        n_on_level     = r_on_level;
        n_off_level    = r_off_level;
        n_fan          = r_fan;
        n_warn         = r_warn;
        n_warn_count   = r_warn_count;

        // long hold of mode
        if (lvl_mode.stable_nxt) begin
            if (r_hold_count != COUNT_MAX) begin
                n_hold_count = r_hold_count + 16'd1;
            end
            if (!r_hold_done && n_hold_count >= r_hold_ticks) begin
                n_hold_done = 1'b1;
                if (r_mode != MODE_CONFIG) begin
                    n_earlier_mode = r_mode;
                    n_mode         = MODE_CONFIG;
                    n_field        = FIELD_ON;
                end else begin
                    save   = 1'b1;
                    n_mode = r_earlier_mode;
                end
                upd = 1'b1;
                clr = 1'b1;
            end
        end

        // mode release
        if (!lvl_mode.stable_nxt && lvl_mode.stable) begin
            if (!r_hold_done) begin
                unique case (r_mode)
                    MODE_CONFIG: begin
                        n_field = !r_field;
                        upd     = 1'b1;
                    end
                    MODE_AUTO: begin
                        unique case (r_view)
                            VIEW_NORMAL: n_view = VIEW_MAX;
                            VIEW_MAX:    n_view = VIEW_MIN;
                            default:     n_view = VIEW_NORMAL;
                        endcase
                        upd = 1'b1;
                        clr = 1'b1;
                    end
                    MODE_MANUAL: begin
                        n_mode = MODE_AUTO;
                        n_view = VIEW_NORMAL;
                        upd    = 1'b1;
                        clr    = 1'b1;
                    end
                    default: ;
                endcase
            end
            n_hold_count = '0;
            n_hold_done  = 1'b0;
        end

        // up and down together enter manual from auto
        if (n_mode == MODE_AUTO && lvl_up.stable_nxt && lvl_down.stable_nxt) begin
            if (!r_combo_done) begin
                n_combo_done = 1'b1;
                n_mode       = MODE_MANUAL;
                combo_now    = 1'b1;
                upd          = 1'b1;
                clr          = 1'b1;
            end
        end else if (!lvl_up.stable_nxt || !lvl_down.stable_nxt) begin
            n_combo_done = 1'b0;
        end

        if (!combo_now && lvl_up.stable_nxt && !lvl_up.stable) begin
            if (n_mode == MODE_MANUAL) begin
                n_fan = 1'b1;
                upd   = 1'b1;
            end else if (n_mode == MODE_CONFIG) begin
                st = step_threshold(n_field, 1'b1, n_on_level, n_off_level,
                                    r_temp_min, r_temp_max, r_diff_min);
                n_on_level  = st.on_lvl;
                n_off_level = st.off_lvl;
                if (st.ok) begin
                    n_warn = 1'b0;
                    upd    = 1'b1;
                end else begin
                    n_warn       = 1'b1;
                    n_warn_count = '0;
                end
            end
        end

        if (!combo_now && lvl_down.stable_nxt && !lvl_down.stable) begin
            if (n_mode == MODE_MANUAL) begin
                n_fan = 1'b0;
                upd   = 1'b1;
            end else if (n_mode == MODE_CONFIG) begin
                st = step_threshold(n_field, 1'b0, n_on_level, n_off_level,
                                    r_temp_min, r_temp_max, r_diff_min);
                n_on_level  = st.on_lvl;
                n_off_level = st.off_lvl;
                if (st.ok) begin
                    n_warn = 1'b0;
                    upd    = 1'b1;
                end else begin
                    n_warn       = 1'b1;
                    n_warn_count = '0;
                end
            end
        end

        // warning timer
        if (n_warn) begin
            if (n_warn_count != COUNT_MAX) begin
                n_warn_count = n_warn_count + 16'd1;
            end
            if (n_warn_count >= r_warn_ticks) begin
                n_warn       = 1'b0;
                n_warn_count = '0;
            end
        end

        n_result.mode            = n_mode;
        n_result.view            = n_view;
        n_result.edit_field      = n_field;
        n_result.on_threshold    = n_on_level;
        n_result.off_threshold   = n_off_level;
        n_result.fan_on          = n_fan;
        n_result.warning         = n_warn;
        n_result.display_update  = upd;
        n_result.display_clear   = clr;
        n_result.save_thresholds = save;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RST;
            r_warn_ticks <= WARN_TICKS_RST;
            r_temp_min   <= TEMP_MIN_RST;
            r_temp_max   <= TEMP_MAX_RST;
            r_diff_min   <= DIFF_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOLD_TICKS: r_hold_ticks <= i_cfg_data;
                REG_WARN_TICKS: r_warn_ticks <= i_cfg_data;
                REG_TEMP_MIN:   r_temp_min   <= $signed(i_cfg_data[7:0]);
                REG_TEMP_MAX:   r_temp_max   <= $signed(i_cfg_data[7:0]);
                REG_DIFF_MIN:   r_diff_min   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count   <= '0;
            r_hold_done    <= 1'b0;
            r_combo_done   <= 1'b0;
            r_mode         <= MODE_AUTO;
            r_earlier_mode <= MODE_AUTO;
            r_view         <= VIEW_NORMAL;
            r_field        <= FIELD_ON;
            r_on_level     <= ON_LEVEL_RST;
            r_off_level    <= OFF_LEVEL_RST;
            r_fan          <= 1'b0;
            r_warn         <= 1'b0;
            r_warn_count   <= '0;
        end else if (in_xfer) begin
            r_hold_count   <= n_hold_count;
            r_hold_done    <= n_hold_done;
            r_combo_done   <= n_combo_done;
            r_mode         <= n_mode;
            r_earlier_mode <= n_earlier_mode;
            r_view         <= n_view;
            r_field        <= n_field;
            r_on_level     <= n_on_level;
            r_off_level    <= n_off_level;
            r_fan          <= n_fan;
            r_warn         <= n_warn;
            r_warn_count   <= n_warn_count;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_q[r_wr_ptr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_xfer) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_xfer) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({in_xfer, out_xfer})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/bpmc_debounce.sv
module bpmc_debounce #(
    parameter int DEBOUNCE_TICKS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_pressed,
    output bpmc_pkg::t_deb_level  o_level
);
    import bpmc_pkg::*;

    localparam int CW = $clog2(DEBOUNCE_TICKS + 1);
    localparam logic [CW-1:0] SETTLED = CW'(DEBOUNCE_TICKS);

    logic          r_prev;
    logic [CW-1:0] r_count;
    logic          r_stable;
    logic [CW-1:0] n_count;
    logic          n_stable;

    always_comb begin
        if (i_pressed != r_prev) begin
            n_count = CW'(1);
        end else if (r_count < SETTLED) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
        n_stable = (n_count == SETTLED) ? i_pressed : r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_count  <= '0;
            r_stable <= 1'b0;
        end else if (i_en) begin
            r_prev   <= i_pressed;
            r_count  <= n_count;
            r_stable <= n_stable;
        end
    end

    assign o_level.stable     = r_stable;
    assign o_level.stable_nxt = n_stable;

endmodule
